>>> hdl/dmk_pkg.sv
// ----------------------------------------------------------------------------
// dmk_pkg
// shared types and constants of the differential evolution mutation kernel
// ----------------------------------------------------------------------------
package dmk_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned DiffW  = ValW + 1;
  localparam int unsigned WgtW   = 18;
  localparam int unsigned RateW  = 17;
  localparam int unsigned FracW  = 16;
  localparam int unsigned CfgDW  = 32;
  localparam int unsigned ChildW = 31;

  localparam logic [WgtW-1:0]  ScaleFReset = 18'd32768;
  localparam logic [WgtW-1:0]  ScaleKReset = 18'd32768;
  localparam logic [RateW-1:0] RateReset   = 17'd65536;

  typedef enum logic [1:0] {
    ACT_ONE_DIFF  = 2'd0,
    ACT_TWO_DIFF  = 2'd1,
    ACT_BASE_TWO  = 2'd2,
    ACT_BASE_ONE  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    CFG_SCALE_F   = 2'd0,
    CFG_SCALE_K   = 2'd1,
    CFG_CROSSOVER = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [WgtW-1:0] scale_f;
    logic [WgtW-1:0] scale_k;
    logic [RateW-1:0] crossover_rate;
  } cfg_t;

  typedef struct packed {
    logic [WgtW-1:0]         w0;
    logic [WgtW-1:0]         wf;
    logic signed [DiffW-1:0] diff0;
    logic signed [DiffW-1:0] diff1;
    logic signed [DiffW-1:0] diff2;
    logic signed [ValW-1:0]  base;
    logic signed [ValW-1:0]  lo;
    logic signed [ValW-1:0]  hi;
    logic                    keep;
    logic                    last;
  } front_item_t;

endpackage

>>> hdl/de_mutation_variable_kernel.sv
// ----------------------------------------------------------------------------
// de_mutation_variable_kernel
// one child decision variable per item from a differential evolution mutation
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid_i / in_ready_o) takes the mutation form, base,
//   five donors, bounds, random fraction and last flag of one variable.
//   output channel (out_valid_o / out_ready_i) returns |child| and the flag.
//   config channel (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i)
//   writes F, K and the crossover rate; it is always ready.
// Throughput: one item per cycle while the receiver keeps out_ready_i high.
// Path: the queue entry is written at the accept edge, then multiply stage,
//   sum stage, round/clamp stage, output register.
// Reset: queue and pipeline empty, F = K = 0.5, crossover rate = always.
// Stall: when the receiver holds out_ready_i low while a result is waiting,
//   the whole back pipeline holds; the two-entry queue keeps taking items
//   until it fills, then in_ready_o drops.
// ----------------------------------------------------------------------------
module de_mutation_variable_kernel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] base_value_i,
  input  logic signed [31:0] donor_one_i,
  input  logic signed [31:0] donor_two_i,
  input  logic signed [31:0] donor_three_i,
  input  logic signed [31:0] donor_four_i,
  input  logic signed [31:0] donor_five_i,
  input  logic signed [31:0] lower_bound_i,
  input  logic signed [31:0] upper_bound_i,
  input  logic [15:0]        random_fraction_i,
  input  logic               last_variable_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [30:0]        child_value_o,
  output logic               last_out_o
);
  import dmk_pkg::*;

  cfg_t        cfg_q;
  front_item_t front_item, queue_item;
  logic        queue_valid, back_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_f        <= ScaleFReset;
      cfg_q.scale_k        <= ScaleKReset;
      cfg_q.crossover_rate <= RateReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SCALE_F:   cfg_q.scale_f        <= cfg_data_i[WgtW-1:0];
        CFG_SCALE_K:   cfg_q.scale_k        <= cfg_data_i[WgtW-1:0];
        CFG_CROSSOVER: cfg_q.crossover_rate <= cfg_data_i[RateW-1:0];
        default: begin
        end
      endcase
    end
  end

  dmk_front u_front (
    .cfg_i             (cfg_q),
    .action_i          (action_i),
    .base_value_i      (base_value_i),
    .donor_one_i       (donor_one_i),
    .donor_two_i       (donor_two_i),
    .donor_three_i     (donor_three_i),
    .donor_four_i      (donor_four_i),
    .donor_five_i      (donor_five_i),
    .lower_bound_i     (lower_bound_i),
    .upper_bound_i     (upper_bound_i),
    .random_fraction_i (random_fraction_i),
    .last_variable_i   (last_variable_i),
    .item_o            (front_item)
  );

  dmk_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (queue_item)
  );

  dmk_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (queue_valid),
    .item_ready_o  (back_ready),
    .item_i        (queue_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .child_value_o (child_value_o),
    .last_out_o    (last_out_o)
  );

endmodule

>>> hdl/dmk_front.sv
// ----------------------------------------------------------------------------
// dmk_front
// classifies an item: selects donor differences and weights, crossover test
// ----------------------------------------------------------------------------
module dmk_front (
  input  dmk_pkg::cfg_t                cfg_i,
  input  logic [1:0]                   action_i,
  input  logic signed [31:0]           base_value_i,
  input  logic signed [31:0]           donor_one_i,
  input  logic signed [31:0]           donor_two_i,
  input  logic signed [31:0]           donor_three_i,
  input  logic signed [31:0]           donor_four_i,
  input  logic signed [31:0]           donor_five_i,
  input  logic signed [31:0]           lower_bound_i,
  input  logic signed [31:0]           upper_bound_i,
  input  logic [15:0]                  random_fraction_i,
  input  logic                         last_variable_i,
  output dmk_pkg::front_item_t         item_o
);
  import dmk_pkg::*;

  logic signed [DiffW-1:0] b_x, d1_x, d2_x, d3_x, d4_x, d5_x;
  logic                    rate_pass;

  assign b_x  = {base_value_i[ValW-1], base_value_i};
  assign d1_x = {donor_one_i[ValW-1], donor_one_i};
  assign d2_x = {donor_two_i[ValW-1], donor_two_i};
  assign d3_x = {donor_three_i[ValW-1], donor_three_i};
  assign d4_x = {donor_four_i[ValW-1], donor_four_i};
  assign d5_x = {donor_five_i[ValW-1], donor_five_i};

  assign rate_pass = ({1'b0, random_fraction_i} < cfg_i.crossover_rate);

  always_comb begin
    item_o.wf    = cfg_i.scale_f;
    item_o.base  = base_value_i;
    item_o.lo    = lower_bound_i;
    item_o.hi    = upper_bound_i;
    item_o.last  = last_variable_i;
    item_o.w0    = cfg_i.scale_f;
    item_o.diff0 = d1_x - d2_x;
    item_o.diff1 = '0;
    item_o.diff2 = '0;
    item_o.keep  = rate_pass;
    case (act_e'(action_i))
      ACT_ONE_DIFF: begin
        item_o.diff0 = d1_x - d2_x;
      end
      ACT_TWO_DIFF: begin
        item_o.diff0 = d1_x - d2_x;
        item_o.diff1 = d3_x - d4_x;
      end
      ACT_BASE_TWO: begin
        item_o.w0    = cfg_i.scale_k;
        item_o.diff0 = b_x - d1_x;
        item_o.diff1 = d2_x - d3_x;
        item_o.diff2 = d4_x - d5_x;
        item_o.keep  = 1'b1;
      end
      default: begin
        item_o.w0    = cfg_i.scale_k;
        item_o.diff0 = b_x - d1_x;
        item_o.diff1 = d2_x - d3_x;
        item_o.keep  = 1'b1;
      end
    endcase
  end

endmodule

>>> hdl/dmk_queue.sv
// ----------------------------------------------------------------------------
// dmk_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module dmk_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  dmk_pkg::front_item_t push_item_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output dmk_pkg::front_item_t pop_item_o
);
  import dmk_pkg::*;

  front_item_t mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> hdl/dmk_back.sv
// ----------------------------------------------------------------------------
// dmk_back
// multiply, sum, round and clamp, then absolute value into the output register
// ----------------------------------------------------------------------------
module dmk_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  input  dmk_pkg::front_item_t item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [30:0]          child_value_o,
  output logic                 last_out_o
);
  import dmk_pkg::*;

  localparam int unsigned ProdW = WgtW + 1 + DiffW;
  localparam int unsigned AccW  = ProdW + 2;
  localparam int unsigned RndW  = AccW - 16;

  logic adv;

  // stage 1: products
  logic                   s1_valid_q;
  logic signed [ProdW-1:0] p0_q, p1_q, p2_q, p0_d, p1_d, p2_d;
  logic signed [ValW-1:0] s1_base_q, s1_lo_q, s1_hi_q;
  logic                   s1_keep_q, s1_last_q;

  // stage 2: sum
  logic                   s2_valid_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [ValW-1:0] s2_base_q, s2_lo_q, s2_hi_q;
  logic                   s2_keep_q, s2_last_q;

  // stage 3: round and clamp
  logic                   s3_valid_q;
  logic signed [AccW-1:0] rnd_sum;
  logic signed [RndW-1:0] vr, vc, hi_x, lo_x;
  logic signed [ValW-1:0] v_q, v_d, s3_base_q;
  logic                   s3_keep_q, s3_last_q;

  // output register
  logic                   out_valid_q;
  logic [ChildW-1:0]      child_q, child_d;
  logic                   last_q;
  logic signed [ValW-1:0] sel;
  logic [ValW-1:0]        neg;

  assign adv          = !out_valid_q || out_ready_i;
  assign item_ready_o = adv;

  assign p0_d = $signed({1'b0, item_i.w0}) * $signed(item_i.diff0);
  assign p1_d = $signed({1'b0, item_i.wf}) * $signed(item_i.diff1);
  assign p2_d = $signed({1'b0, item_i.wf}) * $signed(item_i.diff2);

  assign acc_d = $signed({s1_base_q, 16'h0000}) + p0_q + p1_q + p2_q;

  always_comb begin
    rnd_sum = acc_q + $signed(AccW'(32768));
    vr      = rnd_sum[AccW-1:16];
    hi_x    = RndW'(s2_hi_q);
    lo_x    = RndW'(s2_lo_q);
    vc      = vr;
    if (vc > hi_x) begin
      vc = hi_x;
    end
    if (vc < lo_x) begin
      vc = lo_x;
    end
    v_d = vc[ValW-1:0];
  end

  always_comb begin
    sel = s3_keep_q ? v_q : s3_base_q;
    neg = ValW'(~sel + 32'd1);
    if (sel == $signed({1'b1, {(ValW-1){1'b0}}})) begin
      child_d = '1;
    end else if (sel[ValW-1]) begin
      child_d = neg[ChildW-1:0];
    end else begin
      child_d = sel[ChildW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= item_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_q      <= p0_d;
      p1_q      <= p1_d;
      p2_q      <= p2_d;
      s1_base_q <= item_i.base;
      s1_lo_q   <= item_i.lo;
      s1_hi_q   <= item_i.hi;
      s1_keep_q <= item_i.keep;
      s1_last_q <= item_i.last;

      acc_q     <= acc_d;
      s2_base_q <= s1_base_q;
      s2_lo_q   <= s1_lo_q;
      s2_hi_q   <= s1_hi_q;
      s2_keep_q <= s1_keep_q;
      s2_last_q <= s1_last_q;

      v_q       <= v_d;
      s3_base_q <= s2_base_q;
      s3_keep_q <= s2_keep_q;
      s3_last_q <= s2_last_q;

      child_q   <= child_d;
      last_q    <= s3_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign child_value_o = child_q;
  assign last_out_o    = last_q;

endmodule

>>> hdl/dmk_checker.sv
// ----------------------------------------------------------------------------
// dmk_checker
// port-level checks of the mutation kernel, bound to the top level
// ----------------------------------------------------------------------------
module dmk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [30:0] child_value_o,
  input logic        last_out_o
);

  // result holds while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(child_value_o) && $stable(last_out_o))
    else $error("output item changed while stalled");

  // no result during reset
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // a full queue cannot drain while the back end is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && out_valid_o && !out_ready_i |=> !in_ready_o)
    else $error("input ready while queue full and output stalled");

endmodule

bind de_mutation_variable_kernel dmk_checker u_dmk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .child_value_o (child_value_o),
  .last_out_o    (last_out_o)
);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the differential evolution mutation kernel
// ----------------------------------------------------------------------------
// Items are queued by the main initial block and offered by a falling-edge
// driver; a rising-edge monitor predicts each accepted variable from its own
// copy of F, K and the crossover rate and compares every returned child in
// order. Sender and receiver gaps vary by phase, the receiver is held off once
// long enough to fill the block, and registers change only while it is idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dmk_pkg::*;

  localparam int unsigned CycleLimit     = 300000;
  localparam int unsigned RecvHoldCycles = 80;
  localparam int unsigned BlockItems     = 115;

  typedef struct packed {
    act_e                    action;
    logic signed [ValW-1:0]  base_value;
    logic signed [ValW-1:0]  donor_one;
    logic signed [ValW-1:0]  donor_two;
    logic signed [ValW-1:0]  donor_three;
    logic signed [ValW-1:0]  donor_four;
    logic signed [ValW-1:0]  donor_five;
    logic signed [ValW-1:0]  lower_bound;
    logic signed [ValW-1:0]  upper_bound;
    logic [FracW-1:0]        random_fraction;
    logic                    last_variable;
  } var_item_t;

  typedef struct packed {
    logic [ChildW-1:0] child;
    logic              last;
  } child_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [CfgDW-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [ChildW-1:0]  child_value_o;
  logic               last_out_o;

  var_item_t drv_item = '0;
  var_item_t pending_items[$];
  child_t    expected_children[$];
  child_t    exp_child;
  cfg_t      model_cfg = '{scale_f: ScaleFReset, scale_k: ScaleKReset,
                           crossover_rate: RateReset};

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  logic        item_sent = 1'b0;
  logic        recv_hold_req = 1'b0;
  logic        recv_holding = 1'b0;

  de_mutation_variable_kernel u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (drv_item.action),
    .base_value_i      (drv_item.base_value),
    .donor_one_i       (drv_item.donor_one),
    .donor_two_i       (drv_item.donor_two),
    .donor_three_i     (drv_item.donor_three),
    .donor_four_i      (drv_item.donor_four),
    .donor_five_i      (drv_item.donor_five),
    .lower_bound_i     (drv_item.lower_bound),
    .upper_bound_i     (drv_item.upper_bound),
    .random_fraction_i (drv_item.random_fraction),
    .last_variable_i   (drv_item.last_variable),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .child_value_o     (child_value_o),
    .last_out_o        (last_out_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic child_t predict_child(var_item_t it, cfg_t c);
    child_t res;
    longint base, acc, trial, fw, kw;
    fw = c.scale_f;
    kw = c.scale_k;
    base = it.base_value;
    acc = base * 65536;
    case (it.action)
      ACT_ONE_DIFF: begin
        acc += fw * (longint'(it.donor_one) - longint'(it.donor_two));
      end
      ACT_TWO_DIFF: begin
        acc += fw * (longint'(it.donor_one) - longint'(it.donor_two));
        acc += fw * (longint'(it.donor_three) - longint'(it.donor_four));
      end
      ACT_BASE_TWO: begin
        acc += kw * (base - longint'(it.donor_one));
        acc += fw * (longint'(it.donor_two) - longint'(it.donor_three));
        acc += fw * (longint'(it.donor_four) - longint'(it.donor_five));
      end
      default: begin
        acc += kw * (base - longint'(it.donor_one));
        acc += fw * (longint'(it.donor_two) - longint'(it.donor_three));
      end
    endcase
    trial = (acc + 32768) >>> 16;
    if (trial > longint'(it.upper_bound)) trial = it.upper_bound;
    if (trial < longint'(it.lower_bound)) trial = it.lower_bound;
    // crossover only applies to the plain difference forms
    if ((it.action == ACT_ONE_DIFF || it.action == ACT_TWO_DIFF) &&
        !({1'b0, it.random_fraction} < c.crossover_rate)) begin
      trial = base;
    end
    if (trial < 0) trial = -trial;
    res.child = (trial > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : trial[ChildW-1:0];
    res.last = it.last_variable;
    return res;
  endfunction

  function automatic logic signed [ValW-1:0] rand_q16();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3, 4: return $signed(32'($urandom_range(2**20))) - 32'sd524288;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic var_item_t rand_item(act_e act);
    var_item_t it;
    logic signed [ValW-1:0] a, c;
    it.action = act;
    it.base_value = rand_q16();
    it.donor_one = rand_q16();
    it.donor_two = rand_q16();
    it.donor_three = rand_q16();
    it.donor_four = rand_q16();
    it.donor_five = rand_q16();
    a = rand_q16();
    c = rand_q16();
    case ($urandom_range(9))
      0: begin
        it.lower_bound = 32'sh8000_0000;
        it.upper_bound = 32'sh7FFF_FFFF;
      end
      1: begin
        it.lower_bound = a;
        it.upper_bound = c;
      end
      default: begin
        it.lower_bound = (a < c) ? a : c;
        it.upper_bound = (a < c) ? c : a;
      end
    endcase
    if ($urandom_range(3) == 0) begin
      it.random_fraction = 16'(model_cfg.crossover_rate - 17'($urandom_range(2)));
    end else begin
      it.random_fraction = 16'($urandom());
    end
    it.last_variable = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic act_e rand_action();
    return act_e'($urandom_range(3));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SCALE_F:   model_cfg.scale_f = data[WgtW-1:0];
      CFG_SCALE_K:   model_cfg.scale_k = data[WgtW-1:0];
      CFG_CROSSOVER: model_cfg.crossover_rate = data[RateW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // register value in the low bits, noise above the register width
  task automatic write_settings(input int unsigned f, input int unsigned k,
                                input int unsigned cr);
    logic [CfgDW-1:0] data;
    data = $urandom();
    data[WgtW-1:0] = WgtW'(f);
    write_reg(CFG_SCALE_F, data);
    data = $urandom();
    data[WgtW-1:0] = WgtW'(k);
    write_reg(CFG_SCALE_K, data);
    data = $urandom();
    data[RateW-1:0] = RateW'(cr);
    write_reg(CFG_CROSSOVER, data);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_children.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) pending_items.push_back(rand_item(rand_action()));
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (!in_valid_i || item_sent) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output ready driver
  always @(negedge clk_i) begin
    out_ready_i <= !recv_holding && ($urandom_range(99) >= recv_idle_pct);
  end

  always begin
    @(posedge recv_hold_req);
    recv_holding = 1'b1;
    repeat (RecvHoldCycles) @(negedge clk_i);
    recv_holding = 1'b0;
  end

  // monitor and checker
  always @(posedge clk_i) begin
    item_sent = rst_ni && in_valid_i && in_ready_o;
    if (item_sent) expected_children.push_back(predict_child(drv_item, model_cfg));
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_children.size() == 0) begin
        report_mismatch($sformatf("child %h with no item pending", child_value_o));
      end else begin
        exp_child = expected_children.pop_front();
        if (child_value_o !== exp_child.child)
          report_mismatch($sformatf("child_value %h, want %h", child_value_o,
                                    exp_child.child));
        if (last_out_o !== exp_child.last)
          report_mismatch($sformatf("last_out %b, want %b", last_out_o, exp_child.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    var_item_t it;
    int unsigned phase;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset weights, crossover always keeps
    for (int a = 0; a < 4; a++) begin
      it = rand_item(act_e'(a));
      it.last_variable = a[0];
      pending_items.push_back(it);
    end
    it = rand_item(ACT_ONE_DIFF);
    it.base_value = 32'sh8000_0000;
    it.donor_two = it.donor_one;
    it.lower_bound = 32'sh8000_0000;
    it.upper_bound = 32'sh7FFF_FFFF;
    it.random_fraction = 16'hFFFF;
    pending_items.push_back(it);
    it = rand_item(ACT_TWO_DIFF);
    it.base_value = 32'sh7FFF_FFFF;
    it.donor_one = 32'sh7FFF_FFFF;
    it.donor_two = 32'sh8000_0000;
    it.donor_three = 32'sh7FFF_FFFF;
    it.donor_four = 32'sh8000_0000;
    it.lower_bound = 32'sh8000_0000;
    it.upper_bound = 32'sh7FFF_FFFF;
    pending_items.push_back(it);
    // crossed bounds, the lower bound wins
    it = rand_item(ACT_BASE_TWO);
    it.lower_bound = 32'sd1000;
    it.upper_bound = -32'sd1000;
    pending_items.push_back(it);
    it = rand_item(ACT_BASE_ONE);
    it.base_value = 32'sh8000_0000;
    it.donor_one = 32'sh7FFF_FFFF;
    it.lower_bound = -32'sd5;
    it.upper_bound = 32'sh7FFF_FFFF;
    pending_items.push_back(it);
    // half-step rounding up and toward zero from below
    it = rand_item(ACT_ONE_DIFF);
    it.base_value = '0;
    it.donor_one = 32'sd1;
    it.donor_two = '0;
    it.lower_bound = 32'sh8000_0000;
    it.upper_bound = 32'sh7FFF_FFFF;
    pending_items.push_back(it);
    it.donor_one = '0;
    it.donor_two = 32'sd1;
    it.last_variable = ~it.last_variable;
    pending_items.push_back(it);
    wait_drained();

    // crossover at half
    write_settings(32768, 32768, 32768);
    it = rand_item(ACT_ONE_DIFF);
    it.random_fraction = 16'h7FFF;
    pending_items.push_back(it);
    it.random_fraction = 16'h8000;
    it.base_value = -32'sd700000;
    it.upper_bound = -32'sd10;
    it.lower_bound = -32'sd20;
    pending_items.push_back(it);
    it = rand_item(ACT_TWO_DIFF);
    it.random_fraction = '0;
    pending_items.push_back(it);
    it = rand_item(ACT_BASE_TWO);
    it.random_fraction = 16'hFFFF;
    pending_items.push_back(it);
    wait_drained();

    write_reg(CFG_UNUSED, $urandom());
    write_settings(0, 0, 0);
    it = rand_item(ACT_ONE_DIFF);
    it.random_fraction = '0;
    pending_items.push_back(it);
    pending_items.push_back(rand_item(ACT_TWO_DIFF));
    pending_items.push_back(rand_item(ACT_BASE_TWO));
    pending_items.push_back(rand_item(ACT_BASE_ONE));
    wait_drained();

    write_settings(131072, 131072, 65536);
    for (int a = 0; a < 4; a++) pending_items.push_back(rand_item(act_e'(a)));
    wait_drained();

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 63 : 0;
      recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 36 : 0;
      if (phase == 0) write_settings(131072, 0, 65536);
      else if (phase == 1) write_settings(0, 131072, 0);
      else write_settings($urandom_range(131072), $urandom_range(131072),
                          $urandom_range(65536));
      if (phase == 2) recv_hold_req = 1'b1;
      queue_random(BlockItems);
      wait_drained();
      write_settings($urandom_range(131072), $urandom_range(131072),
                     $urandom_range(65536));
      queue_random(BlockItems);
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/dmk_pkg.sv
hdl/dmk_front.sv
hdl/dmk_queue.sv
hdl/dmk_back.sv
hdl/de_mutation_variable_kernel.sv
hdl/dmk_checker.sv
test/tb_top.sv
